// File: src/rtmp_url_validator_top_defines.svh
// assertion macros for the rtmp url validator
`ifndef RTMP_URL_VALIDATOR_TOP_DEFINES_SVH
`define RTMP_URL_VALIDATOR_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define RUV_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RUV_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ruv_pkg.sv
// shared types, constants and helpers for the rtmp url validator
package ruv_pkg;

    localparam int unsigned MAX_LEN = 256;
    localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
    localparam int unsigned POS_W   = $clog2(MAX_LEN);
    localparam int unsigned OFS_W   = 8;
    localparam int unsigned PORT_W  = 17;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned ERR_W   = 13;

    localparam logic [PORT_W-1:0] PORT_OVER = 17'h10000;
    localparam logic [PORT_W-1:0] PORT_MAX  = 17'h0FFFF;
    localparam logic [CFG_W-1:0]  DEFAULT_PORT_RST = 16'd1935;

    // characters
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // fixed offsets inside the url
    localparam logic [POS_W-1:0] SCHEME_LAST = POS_W'(6);
    localparam logic [POS_W-1:0] HOST_OFS    = POS_W'(7);
    localparam logic [POS_W-1:0] V6_HOST_OFS = POS_W'(8);

    // result status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_FRAGMENT   = 4'd1;
    localparam logic [3:0] ST_CTRL       = 4'd2;
    localparam logic [3:0] ST_SCHEME     = 4'd3;
    localparam logic [3:0] ST_LAYOUT     = 4'd4;
    localparam logic [3:0] ST_USERINFO   = 4'd5;
    localparam logic [3:0] ST_BRACKET    = 4'd6;
    localparam logic [3:0] ST_AUTHORITY  = 4'd7;
    localparam logic [3:0] ST_COLONS     = 4'd8;
    localparam logic [3:0] ST_EMPTY_HOST = 4'd9;
    localparam logic [3:0] ST_BAD_PORT   = 4'd10;
    localparam logic [3:0] ST_EMPTY_PORT = 4'd11;
    localparam logic [3:0] ST_NO_APP     = 4'd12;
    localparam logic [3:0] ST_TOO_LONG   = 4'd13;

    // error flag bits, one below their status code
    localparam int unsigned ERR_FRAGMENT   = 0;
    localparam int unsigned ERR_CTRL       = 1;
    localparam int unsigned ERR_SCHEME     = 2;
    localparam int unsigned ERR_LAYOUT     = 3;
    localparam int unsigned ERR_USERINFO   = 4;
    localparam int unsigned ERR_BRACKET    = 5;
    localparam int unsigned ERR_AUTHORITY  = 6;
    localparam int unsigned ERR_COLONS     = 7;
    localparam int unsigned ERR_EMPTY_HOST = 8;
    localparam int unsigned ERR_BAD_PORT   = 9;
    localparam int unsigned ERR_EMPTY_PORT = 10;
    localparam int unsigned ERR_NO_APP     = 11;
    localparam int unsigned ERR_TOO_LONG   = 12;

    // port flag bits
    localparam int unsigned PF_STARTED = 0;
    localparam int unsigned PF_TEXT    = 1;
    localparam int unsigned PF_BAD     = 2;
    localparam logic [2:0] PF_START_ONLY = 3'b001;

    typedef enum logic [1:0] {
        PH_SCHEME,
        PH_AUTH,
        PH_PATH,
        PH_DEAD
    } t_phase;

    typedef enum logic [1:0] {
        BRK_NONE,
        BRK_OPEN,
        BRK_CLOSED,
        BRK_AFTER
    } t_brk;

    // parse state of one url; also the summary handed to the back end
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        t_phase            phase;
        logic [ERR_W-1:0]  err;
        logic [POS_W-1:0]  auth_end;
        t_brk              brk;
        logic [POS_W-1:0]  close_pos;
        logic [1:0]        colon_cnt;
        logic [POS_W-1:0]  last_colon;
        logic [PORT_W-1:0] port_val;
        logic [2:0]        pflags;
        logic [POS_W-1:0]  query_pos;
        logic [POS_W-1:0]  slash_pos;
    } t_parse;

    localparam t_parse PARSE_CLEAR = t_parse'('0);

    typedef struct packed {
        logic [3:0]       status;
        logic [OFS_W-1:0] host_start;
        logic [OFS_W-1:0] host_len;
        logic [CFG_W-1:0] port_number;
        logic [OFS_W-1:0] app_start;
        logic [OFS_W-1:0] app_len;
        logic [OFS_W-1:0] stream_start;
        logic [OFS_W-1:0] stream_len;
        logic [OFS_W-1:0] tcurl_len;
    } t_result;

    // queue status toward the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] scheme_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h6D;
            3'd3:    c = 8'h70;
            3'd4:    c = CH_COLON;
            3'd5:    c = CH_SLASH;
            3'd6:    c = CH_SLASH;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: src/rtmp_url_validator_top.sv
// top level of the rtmp url validator
// input channel: one url byte per item (i_url_byte, i_last_byte) on i_valid,
// held off by o_stall. a url is any run of items up to one with i_last_byte set.
// output channel: one result item per url on o_valid, held by i_stall; the
// payload stays put while stalled.
// config: i_cfg_we writes i_cfg_wdata into the default port (reset 1935),
// used when the url has no port; write only while the block is idle.
// throughput: one byte per cycle while o_stall is low; the scanner state changes on
// every accepted byte. the last byte's summary is written into the queue, then
// loaded into the result register once the output stage can take it.
// a two-entry summary queue sits between scanner and result stage, so bytes
// keep flowing while a result waits; o_stall rises only when the queue is
// full, i.e. after two finished urls are backed up behind a stalled output.
// reset (synchronous, active low) clears the scan state, the queue and the
// output valid; no clearing pass is needed.
`include "rtmp_url_validator_top_defines.svh"

module rtmp_url_validator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_url_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [7:0]  o_host_start,
    output logic [7:0]  o_host_len,
    output logic [15:0] o_port_number,
    output logic [7:0]  o_app_start,
    output logic [7:0]  o_app_len,
    output logic [7:0]  o_stream_start,
    output logic [7:0]  o_stream_len,
    output logic [7:0]  o_tcurl_len,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import ruv_pkg::*;

    logic [CFG_W-1:0] r_default_port;
    logic             in_accept;
    logic             q_push;
    logic             q_pop;
    t_parse           summary;
    t_parse           q_head;
    t_q_stat          q_stat;
    t_result          result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_port <= DEFAULT_PORT_RST;
        end else if (i_cfg_we) begin
            r_default_port <= i_cfg_wdata;
        end
    end

    assign o_stall   = q_stat.full;
    assign in_accept = i_valid && !o_stall;

    ruv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_url_byte  (i_url_byte),
        .i_last_byte (i_last_byte),
        .o_push      (q_push),
        .o_summary   (summary)
    );

    ruv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (summary),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    ruv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_head_valid   (!q_stat.empty),
        .i_default_port (r_default_port),
        .i_stall        (i_stall),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .o_result       (result)
    );

    assign o_status       = result.status;
    assign o_host_start   = result.host_start;
    assign o_host_len     = result.host_len;
    assign o_port_number  = result.port_number;
    assign o_app_start    = result.app_start;
    assign o_app_len      = result.app_len;
    assign o_stream_start = result.stream_start;
    assign o_stream_len   = result.stream_len;
    assign o_tcurl_len    = result.tcurl_len;

    `RUV_CHECK_NOW(a_q_no_overflow, q_push, !q_stat.full, "summary queue overflow")
    `RUV_CHECK_NOW(a_q_no_underflow, q_pop, !q_stat.empty, "pop from empty summary queue")
    `RUV_CHECK_NOW(a_err_fields_zero, o_valid && o_status != ST_OK, o_host_len == 8'd0 && o_port_number == 16'd0 && o_app_len == 8'd0 && o_stream_len == 8'd0 && o_tcurl_len == 8'd0, "error result with nonzero fields")
    `RUV_CHECK_NEXT(a_pop_loads_output, q_pop, o_valid, "popped summary did not reach the output")

endmodule

// File: src/ruv_front.sv
// front end: per-byte url scanner that builds the parse summary
module ruv_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_url_byte,
    input  logic            i_last_byte,
    output logic            o_push,
    output ruv_pkg::t_parse o_summary
);
    import ruv_pkg::*;

    t_parse r_st;
    t_parse n_st;
    t_parse upd;
    logic [POS_W-1:0] pos;
    logic in_range;

    function automatic t_parse port_byte(input t_parse st, input logic [7:0] b);
        t_parse r;
        logic [PORT_W+3:0] prod;
        r = st;
        prod = '0;
        r.pflags[PF_TEXT] = 1'b1;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            if (st.port_val < PORT_OVER) begin
                prod = ({4'b0, st.port_val} << 3) + ({4'b0, st.port_val} << 1)
                     + (PORT_W+4)'(b - CH_ZERO);
                if (prod > (PORT_W+4)'(PORT_MAX)) begin
                    r.port_val = PORT_OVER;
                end else begin
                    r.port_val = prod[PORT_W-1:0];
                end
            end
        end else begin
            r.pflags[PF_BAD] = 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        upd      = r_st;
        pos      = r_st.len[POS_W-1:0];
        in_range = (r_st.len < LEN_W'(MAX_LEN));
        if (in_range) begin
            if (i_url_byte == CH_HASH) upd.err[ERR_FRAGMENT] = 1'b1;
            if (i_url_byte <= CH_SPACE) upd.err[ERR_CTRL] = 1'b1;
            unique case (r_st.phase)
                PH_SCHEME: begin
                    if (i_url_byte != scheme_char(pos[2:0])) begin
                        upd.err[ERR_SCHEME] = 1'b1;
                        upd.phase = PH_DEAD;
                    end else if (pos == SCHEME_LAST) begin
                        upd.phase = PH_AUTH;
                    end
                end
                PH_AUTH: begin
                    if (i_url_byte == CH_SLASH) begin
                        upd.auth_end = pos;
                        upd.phase    = PH_PATH;
                        if (pos == HOST_OFS) upd.err[ERR_LAYOUT] = 1'b1;
                    end else begin
                        if (i_url_byte == CH_AT) upd.err[ERR_USERINFO] = 1'b1;
                        if (pos == HOST_OFS && i_url_byte == CH_LBRK) begin
                            upd.brk = BRK_OPEN;
                        end else if (r_st.brk == BRK_OPEN) begin
                            if (i_url_byte == CH_RBRK) begin
                                upd.close_pos = pos;
                                upd.brk       = BRK_CLOSED;
                            end
                        end else if (r_st.brk == BRK_CLOSED) begin
                            upd.brk = BRK_AFTER;
                            if (i_url_byte == CH_COLON) begin
                                upd.pflags = PF_START_ONLY;
                            end else begin
                                upd.err[ERR_AUTHORITY] = 1'b1;
                            end
                        end else if (r_st.brk == BRK_AFTER) begin
                            if (r_st.pflags[PF_STARTED]) upd = port_byte(upd, i_url_byte);
                        end else if (i_url_byte == CH_COLON) begin
                            if (r_st.colon_cnt < 2'd2) upd.colon_cnt = r_st.colon_cnt + 2'd1;
                            upd.last_colon = pos;
                            upd.port_val   = '0;
                            upd.pflags     = PF_START_ONLY;
                        end else if (r_st.pflags[PF_STARTED]) begin
                            upd = port_byte(upd, i_url_byte);
                        end
                    end
                end
                PH_PATH: begin
                    if (i_url_byte == CH_QUERY && r_st.query_pos == '0) upd.query_pos = pos;
                    if (i_url_byte == CH_SLASH && r_st.query_pos == '0
                        && r_st.slash_pos == '0) begin
                        upd.slash_pos = pos;
                    end
                end
                PH_DEAD: begin
                end
            endcase
            upd.len = r_st.len + LEN_W'(1);
        end else begin
            // bytes past the limit are dropped
            upd.err[ERR_TOO_LONG] = 1'b1;
        end

        n_st   = r_st;
        o_push = 1'b0;
        if (i_accept) begin
            if (i_last_byte) begin
                o_push = 1'b1;
                n_st   = PARSE_CLEAR;
            end else begin
                n_st = upd;
            end
        end
    end

    assign o_summary = upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= PARSE_CLEAR;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

// File: src/ruv_queue.sv
// two-entry queue of parse summaries between front and back
module ruv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ruv_pkg::t_parse  i_data,
    input  logic             i_pop,
    output ruv_pkg::t_parse  o_head,
    output ruv_pkg::t_q_stat o_stat
);
    import ruv_pkg::*;

    t_parse     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + 2'd1;
        if (!i_push && i_pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop) r_rd_ptr <= !r_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

// File: src/ruv_back.sv
// back end: final checks, status priority and result register
module ruv_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ruv_pkg::t_parse          i_head,
    input  logic                     i_head_valid,
    input  logic [ruv_pkg::CFG_W-1:0] i_default_port,
    input  logic                     i_stall,
    output logic                     o_pop,
    output logic                     o_valid,
    output ruv_pkg::t_result         o_result
);
    import ruv_pkg::*;

    logic             r_valid;
    logic             n_valid;
    t_result          r_res;
    t_result          res;
    logic [ERR_W-1:0] f;
    logic [LEN_W-1:0] p1;
    logic [LEN_W-1:0] q;
    logic [LEN_W-1:0] s_ext;
    logic             load;

    always_comb begin
        f     = i_head.err;
        p1    = {1'b0, i_head.auth_end} + LEN_W'(1);
        s_ext = {1'b0, i_head.slash_pos};
        q     = (i_head.query_pos != '0) ? {1'b0, i_head.query_pos} : i_head.len;

        unique case (i_head.phase)
            PH_SCHEME: f[ERR_SCHEME] = 1'b1;
            PH_AUTH:   f[ERR_LAYOUT] = 1'b1;
            PH_PATH: begin
                if (p1 >= i_head.len) f[ERR_LAYOUT] = 1'b1;
                if (i_head.brk == BRK_OPEN || i_head.close_pos == V6_HOST_OFS) begin
                    f[ERR_BRACKET] = 1'b1;
                end
                if (i_head.brk == BRK_NONE) begin
                    if (i_head.colon_cnt >= 2'd2) begin
                        f[ERR_COLONS] = 1'b1;
                    end else if (i_head.colon_cnt == 2'd1 && i_head.last_colon == HOST_OFS) begin
                        f[ERR_EMPTY_HOST] = 1'b1;
                    end
                end
                if (i_head.pflags[PF_TEXT]) begin
                    if (i_head.pflags[PF_BAD] || i_head.port_val == '0
                        || i_head.port_val > PORT_MAX) begin
                        f[ERR_BAD_PORT] = 1'b1;
                    end
                end else if (i_head.pflags[PF_STARTED]) begin
                    f[ERR_EMPTY_PORT] = 1'b1;
                end
                if (s_ext == '0 || s_ext == p1 || (s_ext + LEN_W'(1)) >= q) begin
                    f[ERR_NO_APP] = 1'b1;
                end
            end
            PH_DEAD: begin
            end
        endcase

        res = '0;
        // lowest flag wins, too-long outranks all
        for (int k = ERR_NO_APP; k >= 0; k--) begin
            if (f[k]) res.status = 4'(k + 1);
        end
        if (f[ERR_TOO_LONG]) res.status = ST_TOO_LONG;

        if (res.status == ST_OK) begin
            if (i_head.brk != BRK_NONE) begin
                res.host_start = OFS_W'(V6_HOST_OFS);
                res.host_len   = OFS_W'(i_head.close_pos - V6_HOST_OFS);
            end else begin
                res.host_start = OFS_W'(HOST_OFS);
                if (i_head.colon_cnt == 2'd1) begin
                    res.host_len = OFS_W'(i_head.last_colon - HOST_OFS);
                end else begin
                    res.host_len = OFS_W'(i_head.auth_end - HOST_OFS);
                end
            end
            res.port_number  = i_head.pflags[PF_TEXT] ? i_head.port_val[CFG_W-1:0]
                                                      : i_default_port;
            res.app_start    = OFS_W'(p1);
            res.app_len      = OFS_W'(s_ext - p1);
            res.stream_start = OFS_W'(s_ext + LEN_W'(1));
            res.stream_len   = OFS_W'(i_head.len - s_ext - LEN_W'(1));
            res.tcurl_len    = OFS_W'(s_ext);
        end

        load    = !r_valid || !i_stall;
        o_pop   = load && i_head_valid;
        n_valid = load ? i_head_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule
